// ===== rtl/rfbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rfbs_pkg;

	localparam int HDR_POS_W = 6;

	localparam logic [HDR_POS_W-1:0] TAG_LEN     = 6'd4;
	localparam logic [HDR_POS_W-1:0] FLAG_POS    = 6'd5;
	localparam logic [HDR_POS_W-1:0] COUNT_START = 6'd28;
	localparam logic [HDR_POS_W-1:0] HEADER_LEN  = 6'd44;

	localparam logic [2:0] ST_RUNNING    = 3'd0;
	localparam logic [2:0] ST_DONE       = 3'd1;
	localparam logic [2:0] ST_BAD_TAG    = 3'd2;
	localparam logic [2:0] ST_BAD_LAYOUT = 3'd3;
	localparam logic [2:0] ST_TRUNCATED  = 3'd4;

	typedef enum logic [2:0] {
		SEC_HEADER,
		SEC_COMMENT,
		SEC_DESC,
		SEC_UNITS,
		SEC_SAMPLES
	} section_t;

	typedef struct packed {
		logic [7:0][7:0] bytes;
		logic [3:0]      nbytes;
		logic            has_status;
		logic [2:0]      status;
	} burst_t;

	function automatic logic [7:0] tag_letter(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h49;
			2'd1: c = 8'h53;
			2'd2: c = 8'h44;
			2'd3: c = 8'h46;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rfbs_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfbs_parser #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [7:0]     in_byte,
	input  wire logic           end_of_stream,
	output rfbs_pkg::burst_t    burst
);

	localparam int CW = COUNT_BITS;
	localparam int PW = rfbs_pkg::HDR_POS_W;

	rfbs_pkg::section_t section_q, section_d;
	logic [PW-1:0] hdr_pos_q, hdr_pos_d;
	logic          sle_q, sle_d;
	logic [CW-1:0] oc_q, oc_d, com_q, com_d, desc_q, desc_d, unit_q, unit_d;
	logic [CW-1:0] sbl_q, sbl_d, rl_q, rl_d, rbl_q, rbl_d;
	logic [2:0]    fill_q, fill_d;
	logic          halted_q, halted_d;
	logic [2:0]    code_q, code_d;
	logic [7:0]    buf_q [8];
	logic          buf_we;
	logic [2:0]    eos_status;
	logic          go_desc, go_units, go_samples;

	logic          is_tag, tag_bad, count_done, oversize, len_bad;
	logic [31:0]   word32;
	logic [CW-1:0] word_c, unit_eff;
	logic          desc_skip, desc_bad, unit_skip, unit_bad;

	assign is_tag     = hdr_pos_q < rfbs_pkg::TAG_LEN;
	assign tag_bad    = in_byte != rfbs_pkg::tag_letter(hdr_pos_q[1:0]);
	assign count_done = fill_q == 3'd3;
	assign word32     = sle_q ? {in_byte, buf_q[2], buf_q[1], buf_q[0]}
	                          : {buf_q[0], buf_q[1], buf_q[2], in_byte};
	assign oversize   = (word32 >> COUNT_BITS) != 32'd0;
	assign word_c     = word32[CW-1:0];
	assign len_bad    = word32 >= 32'(sbl_q);
	assign unit_eff   = (section_q == rfbs_pkg::SEC_HEADER) ? word_c : unit_q;
	assign desc_skip  = (oc_q == '0) && (desc_q == '0);
	assign desc_bad   = (oc_q == '0) || (desc_q < CW'(4));
	assign unit_skip  = (oc_q == '0) && (unit_eff == '0);
	assign unit_bad   = (oc_q == '0) || (unit_eff < CW'(4));

	// state update for one item
	always_comb begin
		section_d  = section_q;
		hdr_pos_d  = hdr_pos_q;
		sle_d      = sle_q;
		oc_d       = oc_q;
		com_d      = com_q;
		desc_d     = desc_q;
		unit_d     = unit_q;
		sbl_d      = sbl_q;
		rl_d       = rl_q;
		rbl_d      = rbl_q;
		fill_d     = fill_q;
		halted_d   = halted_q;
		code_d     = code_q;
		buf_we     = 1'b0;
		go_desc    = 1'b0;
		go_units   = 1'b0;
		go_samples = 1'b0;
		eos_status = rfbs_pkg::ST_TRUNCATED;
		if (!halted_q) begin
			unique case (section_q)
				rfbs_pkg::SEC_HEADER: begin
					if (is_tag && tag_bad) begin
						halted_d = 1'b1;
						code_d   = rfbs_pkg::ST_BAD_TAG;
					end else begin
						if (hdr_pos_q == rfbs_pkg::FLAG_POS) begin
							sle_d = in_byte != 8'd0;
						end
						if (hdr_pos_q >= rfbs_pkg::COUNT_START) begin
							buf_we = 1'b1;
							fill_d = fill_q + 3'd1;
						end
						if (hdr_pos_q >= rfbs_pkg::COUNT_START && count_done) begin
							fill_d = 3'd0;
							if (hdr_pos_q < PW'(rfbs_pkg::COUNT_START + 6'd4)) begin
								oc_d = word_c;
							end else if (hdr_pos_q < PW'(rfbs_pkg::COUNT_START + 6'd8)) begin
								com_d = word_c;
							end else if (hdr_pos_q < PW'(rfbs_pkg::COUNT_START + 6'd12)) begin
								desc_d = word_c;
							end else begin
								unit_d = word_c;
							end
						end
						if (hdr_pos_q >= rfbs_pkg::COUNT_START && count_done && oversize) begin
							halted_d = 1'b1;
							code_d   = rfbs_pkg::ST_BAD_LAYOUT;
						end else begin
							hdr_pos_d = hdr_pos_q + PW'(1);
							if (hdr_pos_q == PW'(rfbs_pkg::HEADER_LEN - 6'd1)) begin
								section_d = rfbs_pkg::SEC_COMMENT;
								sbl_d     = com_q;
								go_desc   = com_q == '0;
							end
						end
					end
				end
				rfbs_pkg::SEC_COMMENT: begin
					sbl_d   = sbl_q - CW'(1);
					go_desc = sbl_q == CW'(1);
				end
				rfbs_pkg::SEC_DESC, rfbs_pkg::SEC_UNITS: begin
					sbl_d = sbl_q - CW'(1);
					if (rbl_q != '0 || (count_done && !len_bad && word32 == 32'd0)) begin
						if (rbl_q != '0) begin
							rbl_d = rbl_q - CW'(1);
						end else begin
							buf_we = 1'b1;
							fill_d = 3'd0;
						end
						if (rbl_q == CW'(1) || rbl_q == '0) begin
							rl_d = rl_q - CW'(1);
							if (rl_q == CW'(1) && sbl_q == CW'(1)) begin
								if (section_q == rfbs_pkg::SEC_DESC) begin
									go_units = 1'b1;
								end else begin
									go_samples = 1'b1;
								end
							end else if (rl_q == CW'(1) || sbl_q < CW'(5)) begin
								halted_d = 1'b1;
								code_d   = rfbs_pkg::ST_BAD_LAYOUT;
							end
						end
					end else begin
						buf_we = 1'b1;
						fill_d = fill_q + 3'd1;
						if (count_done) begin
							fill_d = 3'd0;
							if (len_bad) begin
								halted_d = 1'b1;
								code_d   = rfbs_pkg::ST_BAD_LAYOUT;
							end else begin
								rbl_d = word_c;
							end
						end
					end
				end
				rfbs_pkg::SEC_SAMPLES: begin
					buf_we = 1'b1;
					fill_d = fill_q + 3'd1;
				end
				default: begin
				end
			endcase
		end
		if (go_desc) begin
			section_d = rfbs_pkg::SEC_DESC;
			sbl_d     = desc_q;
			rl_d      = oc_q;
			rbl_d     = '0;
			fill_d    = 3'd0;
			if (desc_skip) begin
				go_units = 1'b1;
			end else if (desc_bad) begin
				halted_d = 1'b1;
				code_d   = rfbs_pkg::ST_BAD_LAYOUT;
			end
		end
		if (go_units) begin
			section_d = rfbs_pkg::SEC_UNITS;
			sbl_d     = unit_eff;
			rl_d      = oc_q;
			rbl_d     = '0;
			fill_d    = 3'd0;
			if (unit_skip) begin
				go_samples = 1'b1;
			end else if (unit_bad) begin
				halted_d = 1'b1;
				code_d   = rfbs_pkg::ST_BAD_LAYOUT;
			end
		end
		if (go_samples) begin
			section_d = rfbs_pkg::SEC_SAMPLES;
			fill_d    = 3'd0;
		end
		if (halted_d) begin
			eos_status = code_d;
		end else if (section_d == rfbs_pkg::SEC_SAMPLES) begin
			eos_status = rfbs_pkg::ST_DONE;
		end
		if (end_of_stream) begin
			section_d = rfbs_pkg::SEC_HEADER;
			hdr_pos_d = '0;
			sle_d     = 1'b0;
			oc_d      = '0;
			com_d     = '0;
			desc_d    = '0;
			unit_d    = '0;
			sbl_d     = '0;
			rl_d      = '0;
			rbl_d     = '0;
			fill_d    = 3'd0;
			halted_d  = 1'b0;
			code_d    = rfbs_pkg::ST_RUNNING;
		end
	end

	// results of one item
	always_comb begin
		burst            = '0;
		burst.has_status = end_of_stream;
		burst.status     = eos_status;
		if (!halted_q) begin
			unique case (section_q)
				rfbs_pkg::SEC_HEADER: begin
					if (is_tag) begin
						if (!tag_bad) begin
							burst.bytes[0] = in_byte;
							burst.nbytes   = 4'd1;
						end
					end else if (hdr_pos_q == rfbs_pkg::FLAG_POS) begin
						burst.bytes[0] = (in_byte != 8'd0) ? 8'd0 : 8'd1;
						burst.nbytes   = 4'd1;
					end else if (hdr_pos_q < rfbs_pkg::COUNT_START) begin
						burst.bytes[0] = in_byte;
						burst.nbytes   = 4'd1;
					end else if (count_done && !oversize) begin
						burst.bytes[0] = in_byte;
						burst.bytes[1] = buf_q[2];
						burst.bytes[2] = buf_q[1];
						burst.bytes[3] = buf_q[0];
						burst.nbytes   = 4'd4;
					end
				end
				rfbs_pkg::SEC_COMMENT: begin
					burst.bytes[0] = in_byte;
					burst.nbytes   = 4'd1;
				end
				rfbs_pkg::SEC_DESC, rfbs_pkg::SEC_UNITS: begin
					if (rbl_q != '0) begin
						burst.bytes[0] = in_byte;
						burst.nbytes   = 4'd1;
					end else if (count_done && !len_bad) begin
						burst.bytes[0] = in_byte;
						burst.bytes[1] = buf_q[2];
						burst.bytes[2] = buf_q[1];
						burst.bytes[3] = buf_q[0];
						burst.nbytes   = 4'd4;
					end
				end
				rfbs_pkg::SEC_SAMPLES: begin
					if (fill_q == 3'd7) begin
						burst.bytes[0] = in_byte;
						for (int k = 1; k < 8; k++) begin
							burst.bytes[3'(k)] = buf_q[3'(7 - k)];
						end
						burst.nbytes = 4'd8;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_q <= rfbs_pkg::SEC_HEADER;
			hdr_pos_q <= '0;
			sle_q     <= 1'b0;
			oc_q      <= '0;
			com_q     <= '0;
			desc_q    <= '0;
			unit_q    <= '0;
			sbl_q     <= '0;
			rl_q      <= '0;
			rbl_q     <= '0;
			fill_q    <= 3'd0;
			halted_q  <= 1'b0;
			code_q    <= rfbs_pkg::ST_RUNNING;
		end else if (accept) begin
			section_q <= section_d;
			hdr_pos_q <= hdr_pos_d;
			sle_q     <= sle_d;
			oc_q      <= oc_d;
			com_q     <= com_d;
			desc_q    <= desc_d;
			unit_q    <= unit_d;
			sbl_q     <= sbl_d;
			rl_q      <= rl_d;
			rbl_q     <= rbl_d;
			fill_q    <= fill_d;
			halted_q  <= halted_d;
			code_q    <= code_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && buf_we) begin
			buf_q[fill_q] <= in_byte;
		end
	end

	a_stream_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_stream |=> section_q == rfbs_pkg::SEC_HEADER && hdr_pos_q == '0 &&
			!halted_q)
		else $error("state not back to header after end of stream");

	a_halt_code: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> code_q == rfbs_pkg::ST_BAD_TAG || code_q == rfbs_pkg::ST_BAD_LAYOUT)
		else $error("halted without an error code");

	a_prefix_fill: assert property (@(posedge clk) disable iff (!arst_n)
		section_q == rfbs_pkg::SEC_DESC || section_q == rfbs_pkg::SEC_UNITS ||
			section_q == rfbs_pkg::SEC_HEADER |-> fill_q < 3'd4)
		else $error("four-byte group overfilled");

endmodule

`default_nettype wire

// ===== rtl/rfbs_burst.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfbs_burst (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire rfbs_pkg::burst_t data,
	output logic                  load_ok,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic                  byte_valid,
	output logic [2:0]            status,
	output logic                  end_of_run
);

	rfbs_pkg::burst_t burst_q;
	logic [3:0] ptr_q;
	logic [3:0] total_q;
	logic       last;
	logic       is_byte;

	assign out_valid = ptr_q != total_q;
	assign last      = out_valid && (ptr_q == total_q - 4'd1);
	assign load_ok   = !out_valid || (last && out_ready);
	assign is_byte   = ptr_q < burst_q.nbytes;

	assign out_byte   = is_byte ? burst_q.bytes[ptr_q[2:0]] : 8'd0;
	assign byte_valid = is_byte;
	assign status     = is_byte ? rfbs_pkg::ST_RUNNING : burst_q.status;
	assign end_of_run = !is_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= 4'd0;
			total_q <= 4'd0;
		end else if (load) begin
			ptr_q   <= 4'd0;
			total_q <= data.nbytes + {3'd0, data.has_status};
		end else if (out_valid && out_ready) begin
			ptr_q <= ptr_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_q <= data;
		end
	end

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= total_q)
		else $error("read pointer past end of burst");

	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> load_ok)
		else $error("burst overwritten before drained");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_run |-> last)
		else $error("status item not last of burst");

endmodule

`default_nettype wire

// ===== rtl/record_file_byte_order_swapper_core.sv =====
// record file byte order swapper
// input channel: in_valid/in_ready carry one source file byte per item
//   (in_byte, end_of_stream marks the final byte of the file)
// output channel: out_valid/out_ready carry one result per item, either a
//   converted byte (byte_valid 1) or the closing status (end_of_run 1)
// each accepted byte is decoded combinationally and its results (0 to 8
//   bytes, plus the status on the final byte) go into a burst register
// latency: a result is offered the cycle after its byte is accepted
// throughput: one item per cycle on each side while out_ready holds; a
//   byte completing an 8-byte sample word or a 4-byte count or prefix
//   gives several results; input waits as the burst drains, one per cycle
// a new byte is taken in the cycle the last result of a burst is taken
// receiver stall: results hold in the burst register, in_ready drops
// reset: back to the header section, burst register empty, no clearing pass
// after a status result the block is ready for the next file
`timescale 1ns / 1ps
`default_nettype none

module record_file_byte_order_swapper_core #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_stream,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic [2:0]      status,
	output logic            end_of_run
);

	rfbs_pkg::burst_t burst;
	logic accept;
	logic load_ok;

	assign in_ready = load_ok;
	assign accept   = in_valid && load_ok;

	rfbs_parser #(
		.COUNT_BITS(COUNT_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.end_of_stream(end_of_stream),
		.burst        (burst)
	);

	rfbs_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.data      (burst),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.byte_valid(byte_valid),
		.status    (status),
		.end_of_run(end_of_run)
	);

endmodule

`default_nettype wire

// ===== test/tb_record_file_byte_order_swapper_core.sv =====
`timescale 1ns / 1ps

module tb_record_file_byte_order_swapper_core;

	localparam int CNT_W = 32;
	localparam int HOLD_AT = 120;
	localparam int HOLD_LEN = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [7:0] MAGIC [4] = '{8'h49, 8'h53, 8'h44, 8'h46};

	typedef struct {
		logic [7:0] data;
		logic       eos;
		bit         hold;
	} src_item_t;

	typedef struct {
		logic [7:0] data;
		logic       is_byte;
		logic [2:0] st;
		logic       last;
	} swap_res_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_stream = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [2:0] status;
	logic       end_of_run;

	src_item_t  file_bytes[$];
	logic [7:0] file_q[$];
	swap_res_t  swapped_due[$];
	swap_res_t  got;
	int         errors = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	logic [31:0] rx_cycle = 0;
	int         quiet = 0;

	// swapper state
	rfbs_pkg::section_t m_sec;
	logic [5:0] m_hpos;
	bit         m_le;
	logic [31:0] m_objs, m_cmt_len, m_desc_len, m_unit_len;
	logic [31:0] m_left, m_recs, m_body;
	logic [7:0] m_grp [8];
	int         m_fill;
	bit         m_halted;
	logic [2:0] m_code;

	record_file_byte_order_swapper_core #(.COUNT_BITS(CNT_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.status(status),
		.end_of_run(end_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic reset_swapper();
		m_sec = rfbs_pkg::SEC_HEADER;
		m_hpos = '0;
		m_le = 1'b0;
		m_objs = '0;
		m_cmt_len = '0;
		m_desc_len = '0;
		m_unit_len = '0;
		m_left = '0;
		m_recs = '0;
		m_body = '0;
		for (int i = 0; i < 8; i++) m_grp[i] = 8'h00;
		m_fill = 0;
		m_halted = 1'b0;
		m_code = rfbs_pkg::ST_RUNNING;
	endtask

	task automatic put_byte(input logic [7:0] b);
		swapped_due.push_back('{data: b, is_byte: 1'b1, st: rfbs_pkg::ST_RUNNING,
			last: 1'b0});
	endtask

	task automatic put_reversed(input int n);
		for (int i = n; i > 0; i--) put_byte(m_grp[(i - 1) & 7]);
	endtask

	task automatic halt(input logic [2:0] code);
		m_halted = 1'b1;
		m_code = code;
	endtask

	function automatic logic [63:0] grp_word();
		if (m_le)
			return {32'd0, m_grp[3], m_grp[2], m_grp[1], m_grp[0]};
		return {32'd0, m_grp[0], m_grp[1], m_grp[2], m_grp[3]};
	endfunction

	// a finished description or unit section moves on; a bad layout halts
	task automatic check_walk();
		bit again;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			if (m_recs == 0 && m_left == 0) begin
				if (m_sec == rfbs_pkg::SEC_DESC) begin
					m_sec = rfbs_pkg::SEC_UNITS;
					m_left = m_unit_len;
					m_recs = m_objs;
					m_body = '0;
					m_fill = 0;
					again = 1'b1;
				end else begin
					m_sec = rfbs_pkg::SEC_SAMPLES;
					m_fill = 0;
				end
			end else if (m_recs == 0 || m_left < 4) begin
				halt(rfbs_pkg::ST_BAD_LAYOUT);
			end
		end
	endtask

	task automatic start_walk(input rfbs_pkg::section_t s, input logic [31:0] len);
		m_sec = s;
		m_left = len;
		m_recs = m_objs;
		m_body = '0;
		m_fill = 0;
		check_walk();
	endtask

	task automatic record_done();
		m_recs = m_recs - 1;
		check_walk();
	endtask

	task automatic header_byte(input logic [7:0] b);
		logic [5:0]  p;
		logic [63:0] v;
		p = m_hpos;
		if (p < rfbs_pkg::TAG_LEN) begin
			if (b != MAGIC[p[1:0]]) begin
				halt(rfbs_pkg::ST_BAD_TAG);
				return;
			end
			put_byte(b);
		end else if (p == rfbs_pkg::FLAG_POS) begin
			m_le = (b != 0);
			put_byte((b != 0) ? 8'h00 : 8'h01);
		end else if (p < rfbs_pkg::COUNT_START) begin
			put_byte(b);
		end else begin
			m_grp[m_fill & 7] = b;
			m_fill++;
			if (m_fill == 4) begin
				v = grp_word();
				m_fill = 0;
				if ((v >> CNT_W) != 0) begin
					halt(rfbs_pkg::ST_BAD_LAYOUT);
					return;
				end
				if (p < 32) m_objs = v[31:0];
				else if (p < 36) m_cmt_len = v[31:0];
				else if (p < 40) m_desc_len = v[31:0];
				else m_unit_len = v[31:0];
				put_reversed(4);
			end
		end
		m_hpos = p + 1;
		if (m_hpos == rfbs_pkg::HEADER_LEN) begin
			m_sec = rfbs_pkg::SEC_COMMENT;
			m_left = m_cmt_len;
			if (m_left == 0) start_walk(rfbs_pkg::SEC_DESC, m_desc_len);
		end
	endtask

	task automatic walk_byte(input logic [7:0] b);
		logic [63:0] len;
		if (m_body > 0) begin
			put_byte(b);
			m_left = m_left - 1;
			m_body = m_body - 1;
			if (m_body == 0) record_done();
			return;
		end
		m_grp[m_fill & 7] = b;
		m_fill++;
		m_left = m_left - 1;
		if (m_fill == 4) begin
			len = grp_word();
			m_fill = 0;
			if (len > {32'd0, m_left}) begin
				halt(rfbs_pkg::ST_BAD_LAYOUT);
				return;
			end
			put_reversed(4);
			if (len == 0) record_done();
			else m_body = len[31:0];
		end
	endtask

	task automatic swap_byte(input logic [7:0] b, input logic eos);
		logic [2:0] st;
		if (!m_halted) begin
			case (m_sec)
				rfbs_pkg::SEC_HEADER: header_byte(b);
				rfbs_pkg::SEC_COMMENT: begin
					put_byte(b);
					m_left = m_left - 1;
					if (m_left == 0) start_walk(rfbs_pkg::SEC_DESC, m_desc_len);
				end
				rfbs_pkg::SEC_DESC, rfbs_pkg::SEC_UNITS: walk_byte(b);
				default: begin
					m_grp[m_fill & 7] = b;
					m_fill++;
					if (m_fill == 8) begin
						put_reversed(8);
						m_fill = 0;
					end
				end
			endcase
		end
		if (eos) begin
			if (m_halted) st = m_code;
			else if (m_sec == rfbs_pkg::SEC_SAMPLES) st = rfbs_pkg::ST_DONE;
			else st = rfbs_pkg::ST_TRUNCATED;
			swapped_due.push_back('{data: 8'h00, is_byte: 1'b0, st: st, last: 1'b1});
			reset_swapper();
		end
	endtask

	function automatic logic [7:0] rnd8(input int lo, input int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	task automatic put_count(input logic [31:0] v, input bit le);
		for (int i = 0; i < 4; i++) file_q.push_back(le ? v[8 * i +: 8] : v[8 * (3 - i) +: 8]);
	endtask

	// well-formed file unless skew shifts the description length in the header
	task automatic build_file(input int objs, input bit le, input int cmt, input int nsamp,
			input int skew);
		int dl[$];
		int ul[$];
		logic [31:0] dlen;
		logic [31:0] ulen;
		dlen = 0;
		ulen = 0;
		for (int i = 0; i < objs; i++) begin
			dl.push_back($urandom_range(0, 5));
			ul.push_back($urandom_range(0, 5));
			dlen = dlen + 4 + 32'(dl[i]);
			ulen = ulen + 4 + 32'(ul[i]);
		end
		file_q.delete();
		for (int i = 0; i < 4; i++) file_q.push_back(MAGIC[i]);
		file_q.push_back(rnd8(0, 255));
		file_q.push_back(le ? rnd8(1, 255) : 8'h00);
		for (int i = 6; i < 28; i++) file_q.push_back(rnd8(0, 255));
		put_count(32'(objs), le);
		put_count(32'(cmt), le);
		put_count(dlen + 32'(skew), le);
		put_count(ulen, le);
		for (int i = 0; i < cmt; i++) file_q.push_back(rnd8(0, 255));
		for (int i = 0; i < objs; i++) begin
			put_count(32'(dl[i]), le);
			for (int j = 0; j < dl[i]; j++) file_q.push_back(rnd8(0, 255));
		end
		for (int i = 0; i < objs; i++) begin
			put_count(32'(ul[i]), le);
			for (int j = 0; j < ul[i]; j++) file_q.push_back(rnd8(0, 255));
		end
		for (int i = 0; i < nsamp; i++) file_q.push_back(rnd8(0, 255));
	endtask

	task automatic send_file(input bit pause, input int cut);
		for (int i = 0; i < cut; i++)
			file_bytes.push_back('{data: file_q[i], eos: (i == cut - 1), hold: (pause && i == 0)});
	endtask

	// sender: bursts with gaps, may wait for all results before a marked item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (file_bytes.size() != 0 &&
					!(file_bytes[0].hold && (in_valid || swapped_due.size() != 0))) begin
				in_byte <= file_bytes[0].data;
				end_of_stream <= file_bytes[0].eos;
				in_valid <= 1'b1;
				void'(file_bytes.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: a rotating stall pattern, broken by one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN)
				out_ready <= 1'b0;
			else begin
				case (rx_cycle[7:6])
					2'd0: out_ready <= 1'b1;
					2'd1: out_ready <= 1'($urandom_range(0, 1));
					2'd2: out_ready <= (rx_cycle[1:0] == 2'd0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (swapped_due.size() == 0) begin
					if (errors < 50)
						$display("%0t: unexpected item: out_byte %h byte_valid %b status %0d end_of_run %b",
							$time, out_byte, byte_valid, status, end_of_run);
					errors++;
				end else begin
					got = swapped_due.pop_front();
					if (out_byte !== got.data || byte_valid !== got.is_byte ||
							status !== got.st || end_of_run !== got.last) begin
						if (errors < 50) begin
							if (out_byte !== got.data)
								$display("%0t: out_byte expected %h actual %h", $time, got.data, out_byte);
							if (byte_valid !== got.is_byte)
								$display("%0t: byte_valid expected %b actual %b", $time, got.is_byte,
									byte_valid);
							if (status !== got.st)
								$display("%0t: status expected %0d actual %0d", $time, got.st, status);
							if (end_of_run !== got.last)
								$display("%0t: end_of_run expected %b actual %b", $time, got.last,
									end_of_run);
						end
						errors++;
					end
				end
			end
			if (in_valid && in_ready) swap_byte(in_byte, end_of_stream);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("record_file_byte_order_swapper_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		reset_swapper();

		// short streams: tag errors, halted bytes, early end
		file_q = '{8'h49};
		send_file(1'b0, file_q.size());
		file_q = '{8'h00};
		send_file(1'b0, file_q.size());
		file_q = '{8'h49, 8'h53, 8'h44, 8'hFF, 8'h00, 8'h46};
		send_file(1'b0, file_q.size());
		file_q = '{8'hFF};
		send_file(1'b0, file_q.size());
		file_q = '{8'h49, 8'h53, 8'h44, 8'h46, 8'hA5};
		send_file(1'b0, file_q.size());
		file_q = '{8'h49, 8'h58, 8'h44};
		send_file(1'b0, file_q.size());

		// empty sections
		build_file(0, 1'b0, 0, 0, 0);
		send_file(1'b0, file_q.size());

		// little endian with partial sample word, after all results are back
		build_file(1, 1'b1, 2, 11, 0);
		send_file(1'b1, file_q.size());

		// short description length halts at the first prefix or on entry
		build_file(1, 1'b0, 0, 3, -1);
		send_file(1'b0, 48);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (file_bytes.size() != 0 || in_valid || swapped_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && swapped_due.size() == 0)
			$display("record_file_byte_order_swapper_core regression: pass");
		else
			$display("record_file_byte_order_swapper_core regression: fail");
		$finish;
	end

endmodule
